/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define RBHT_ASSERT(lbl, clk_s, rstn_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) \
	else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define RBHT_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
	else $error(msg);

`endif

/* rtl/rbht_pkg.sv */
// Package: widths, status codes, sample snapshot type and a popcount helper function.
`default_nettype none

package rbht_pkg;

	localparam int MAX_BYTES   = 4096;
	localparam int COUNT_W     = 13;
	localparam int ONES_W      = 16;
	localparam int TRANS_W     = 15;
	localparam int SUM_W       = 20;
	localparam int SQ_W        = 28;
	localparam int MIN_W       = 13;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [MIN_W-1:0] MIN_FLOOR = MIN_W'(2);
	localparam logic [MIN_W-1:0] MIN_RESET = MIN_W'(32);

	typedef enum logic [2:0] {
		STAT_PASS   = 3'd0,
		STAT_SKIP   = 3'd1,
		STAT_FREQ   = 3'd2,
		STAT_RUNS   = 3'd3,
		STAT_SERIAL = 3'd4,
		STAT_LONG   = 3'd5
	} status_t;

	// Accumulated sample state handed from front to back.
	typedef struct packed {
		logic [COUNT_W-1:0] n;
		logic [ONES_W-1:0]  ones;
		logic [TRANS_W-1:0] trans;
		logic [SUM_W-1:0]   sum;
		logic [SQ_W-1:0]    sq;
		logic [SQ_W-1:0]    pair;
		logic [7:0]         last_b;
		logic [7:0]         first_b;
		logic               ovf;
	} snapshot_t;

	function automatic logic [3:0] popcount8(input logic [7:0] v);
		logic [3:0] c;
		c = 4'd0;
		for (int i = 0; i < 8; i++) begin
			c = c + 4'(v[i]);
		end
		return c;
	endfunction

endpackage

`default_nettype wire

/* rtl/rbht_chan_if.sv */
// Channel interfaces: sample bytes in, verdicts out, configuration writes.
`default_nettype none

interface rbht_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface rbht_out_if;
	logic        valid;
	logic        ready;
	logic        passed;
	logic [2:0]  status;
	logic [15:0] ones_count;
	logic [14:0] transition_count;

	modport source (output valid, output passed, output status, output ones_count,
		output transition_count, input ready);
	modport sink   (input valid, input passed, input status, input ones_count,
		input transition_count, output ready);
endinterface

interface rbht_cfg_if;
	logic        valid;
	logic        ready;
	logic [12:0] min_bytes;

	modport source (output valid, output min_bytes, input ready);
	modport sink   (input valid, input min_bytes, output ready);
endinterface

`default_nettype wire

/* rtl/rng_byte_health_test.sv */
// Top level: random byte health test (monobit, runs, serial correlation).
//
//   channel   dir  handshake       word
//   samples   in   valid/ready     data_byte, last_byte
//   verdicts  out  valid/ready     passed, status, ones_count, transition_count
//   cfg       in   valid/ready     min_bytes (always ready)
//
// One byte per cycle enters the accumulators while the queue is not full; a last byte queues a snapshot.
// The judge steps one sample at a time through PA, SS, NQ, LF on its one shared multiplier, then DIFF, ABS, JUDGE.
// Two snapshots may wait; samples stalls only while that queue is full.
// A held verdict keeps the judge in JUDGE; the front end still takes bytes until the queue is full.
// Reset clears all counters, the queue and the output; min_bytes returns to 32.
`default_nettype none
`include "assert_macros.svh"

module rng_byte_health_test (
	input  wire logic clk,
	input  wire logic arst_n,
	rbht_in_if.sink   samples,
	rbht_out_if.source verdicts,
	rbht_cfg_if.sink  cfg
);
	import rbht_pkg::*;

	logic      q_push;
	snapshot_t q_push_snap;
	logic      q_pop;
	logic      q_full;
	logic      q_head_valid;
	snapshot_t q_head;

	rbht_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (samples),
		.q_full    (q_full),
		.push      (q_push),
		.push_snap (q_push_snap)
	);

	rbht_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_snap  (q_push_snap),
		.pop        (q_pop),
		.full       (q_full),
		.head_valid (q_head_valid),
		.head       (q_head)
	);

	rbht_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.head_valid (q_head_valid),
		.head       (q_head),
		.pop        (q_pop),
		.verdicts   (verdicts)
	);

	`RBHT_ASSERT(a_no_push_full, clk, arst_n, !(q_push && q_full), "push into full queue")
	`RBHT_ASSERT(a_pop_has_head, clk, arst_n, !q_pop || q_head_valid, "pop from empty queue")
	`RBHT_ASSERT_NEXT(a_pop_gives_word, clk, arst_n, q_pop, verdicts.valid, "pop without verdict")
	`RBHT_ASSERT(a_passed_match, clk, arst_n, !verdicts.valid || (verdicts.passed == ((verdicts.status == STAT_PASS) || (verdicts.status == STAT_SKIP))), "passed disagrees with status")

endmodule

`default_nettype wire

/* rtl/rbht_front.sv */
// Front end: takes one byte per cycle while the queue is not full and updates the sample accumulators.
`default_nettype none

module rbht_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	rbht_in_if.sink            samples,
	input  wire logic          q_full,
	output logic               push,
	output rbht_pkg::snapshot_t push_snap
);
	import rbht_pkg::*;

	logic [COUNT_W-1:0] cnt_q;
	logic [ONES_W-1:0]  ones_q;
	logic [TRANS_W-1:0] trans_q;
	logic               pbit_q;
	logic [SUM_W-1:0]   sum_q;
	logic [SQ_W-1:0]    sq_q;
	logic [SQ_W-1:0]    pair_q;
	logic [7:0]         pbyte_q;
	logic [7:0]         first_q;
	logic               ovf_q;

	logic       accept;
	logic       room;
	logic       first;
	logic       p;
	logic [7:0] b;
	logic [7:0] tvec;
	logic [15:0] b_sq;
	logic [15:0] b_pair;
	snapshot_t   nxt;
	logic        nxt_pbit;

	assign samples.ready = !q_full;
	assign accept        = samples.valid && samples.ready;
	assign b             = samples.data_byte;
	assign room          = cnt_q < COUNT_W'(MAX_BYTES);
	assign first         = cnt_q == '0;
	assign p             = first ? b[7] : pbit_q;
	assign tvec          = {b[7] ^ p, b[6:0] ^ b[7:1]};
	assign b_sq          = 16'(b) * 16'(b);
	assign b_pair        = 16'(pbyte_q) * 16'(b);

	always_comb begin
		nxt.n       = cnt_q;
		nxt.ones    = ones_q;
		nxt.trans   = trans_q;
		nxt.sum     = sum_q;
		nxt.sq      = sq_q;
		nxt.pair    = pair_q;
		nxt.last_b  = pbyte_q;
		nxt.first_b = first_q;
		nxt.ovf     = ovf_q;
		nxt_pbit    = pbit_q;
		if (room) begin
			nxt.n       = cnt_q + COUNT_W'(1);
			nxt.ones    = ones_q + ONES_W'(popcount8(b));
			nxt.trans   = trans_q + TRANS_W'(popcount8(tvec));
			nxt.sum     = sum_q + SUM_W'(b);
			nxt.sq      = sq_q + SQ_W'(b_sq);
			nxt.pair    = first ? pair_q : pair_q + SQ_W'(b_pair);
			nxt.last_b  = b;
			nxt.first_b = first ? b : first_q;
			nxt_pbit    = b[0];
		end else begin
			nxt.ovf = 1'b1;
		end
	end

	assign push      = accept && samples.last_byte;
	assign push_snap = nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			ones_q  <= '0;
			trans_q <= '0;
			pbit_q  <= 1'b0;
			sum_q   <= '0;
			sq_q    <= '0;
			pair_q  <= '0;
			pbyte_q <= '0;
			first_q <= '0;
			ovf_q   <= 1'b0;
		end else if (accept) begin
			if (samples.last_byte) begin
				cnt_q   <= '0;
				ones_q  <= '0;
				trans_q <= '0;
				pbit_q  <= 1'b0;
				sum_q   <= '0;
				sq_q    <= '0;
				pair_q  <= '0;
				pbyte_q <= '0;
				first_q <= '0;
				ovf_q   <= 1'b0;
			end else begin
				cnt_q   <= nxt.n;
				ones_q  <= nxt.ones;
				trans_q <= nxt.trans;
				pbit_q  <= nxt_pbit;
				sum_q   <= nxt.sum;
				sq_q    <= nxt.sq;
				pair_q  <= nxt.pair;
				pbyte_q <= nxt.last_b;
				first_q <= nxt.first_b;
				ovf_q   <= nxt.ovf;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/rbht_queue.sv */
// Short queue of finished sample snapshots between front and back.
`default_nettype none

module rbht_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire rbht_pkg::snapshot_t push_snap,
	input  wire logic          pop,
	output logic               full,
	output logic               head_valid,
	output rbht_pkg::snapshot_t head
);
	import rbht_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	snapshot_t        mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [CNT_W-1:0] count_q;

	logic do_push;
	logic do_pop;

	assign full       = count_q == CNT_W'(QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head       = mem_q[rptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
		return (ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= push_snap;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= ptr_inc(wptr_q);
			end
			if (do_pop) begin
				rptr_q <= ptr_inc(rptr_q);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

/* rtl/rbht_back.sv */
// Back end: judges one snapshot with a shared multiplier and holds the verdict.
`default_nettype none

module rbht_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	rbht_cfg_if.sink           cfg,
	input  wire logic          head_valid,
	input  wire rbht_pkg::snapshot_t head,
	output logic               pop,
	rbht_out_if.source         verdicts
);
	import rbht_pkg::*;

	localparam int PROD_W = SUM_W + SQ_W;
	localparam int PA_W   = COUNT_W + SQ_W;
	localparam int SS_W   = 2 * SUM_W;
	localparam int LF_W   = 16;
	localparam int NUM_W  = PA_W + 2;
	localparam int ABS_W  = NUM_W - 1;
	localparam int CMP_W  = ABS_W + 4;

	typedef enum logic [7:0] {
		B_IDLE  = 8'b0000_0001,
		B_PA    = 8'b0000_0010,
		B_SS    = 8'b0000_0100,
		B_NQ    = 8'b0000_1000,
		B_LF    = 8'b0001_0000,
		B_DIFF  = 8'b0010_0000,
		B_ABS   = 8'b0100_0000,
		B_JUDGE = 8'b1000_0000
	} bstate_t;

	bstate_t                   state_q;
	logic [MIN_W-1:0]          min_bytes_q;
	logic [PA_W-1:0]           pa_q;
	logic [SS_W-1:0]           ss_q;
	logic [PA_W-1:0]           nq_q;
	logic [LF_W-1:0]           lf_q;
	logic signed [NUM_W-1:0]   num_q;
	logic signed [NUM_W-1:0]   den_q;
	logic [ABS_W-1:0]          anum_q;
	logic [ABS_W-1:0]          aden_q;
	logic                      out_valid_q;
	logic                      passed_q;
	status_t                   status_q;
	logic [ONES_W-1:0]         ones_q;
	logic [TRANS_W-1:0]        trans_q;

	logic [SUM_W-1:0]          mul_a;
	logic [SQ_W-1:0]           mul_b;
	logic [PROD_W-1:0]         prod;
	logic [COUNT_W-1:0]        nm1;
	logic [MIN_W-1:0]          minimum;
	logic [ONES_W:0]           n4;
	logic [ONES_W:0]           dev;
	logic [ONES_W+3:0]         dev5;
	logic [TRANS_W+3:0]        t10;
	logic [COUNT_W+2:0]        nm1_5;
	logic                      freq_fail;
	logic                      runs_fail;
	logic                      serial_fail;
	logic [CMP_W-1:0]          num10;
	logic [CMP_W-1:0]          den3;
	logic                      slot_free;
	status_t                   verdict;

	assign cfg.ready = 1'b1;
	assign nm1       = head.n - COUNT_W'(1);

	always_comb begin
		case (state_q)
			B_PA: begin
				mul_a = SUM_W'(nm1);
				mul_b = head.pair;
			end
			B_SS: begin
				mul_a = head.sum;
				mul_b = SQ_W'(head.sum);
			end
			B_NQ: begin
				mul_a = SUM_W'(head.n);
				mul_b = head.sq;
			end
			B_LF: begin
				mul_a = SUM_W'(head.last_b);
				mul_b = SQ_W'(head.first_b);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

	assign minimum   = (min_bytes_q < MIN_FLOOR) ? MIN_FLOOR : min_bytes_q;
	assign n4        = (ONES_W + 1)'({head.n, 2'b00});
	assign dev       = ((ONES_W + 1)'(head.ones) >= n4) ? (ONES_W + 1)'(head.ones) - n4
		: n4 - (ONES_W + 1)'(head.ones);
	assign dev5      = (ONES_W + 4)'({dev, 2'b00}) + (ONES_W + 4)'(dev);
	assign freq_fail = dev5 > (ONES_W + 4)'(n4);
	assign t10       = (TRANS_W + 4)'({head.trans, 3'b000}) + (TRANS_W + 4)'({head.trans, 1'b0});
	assign nm1_5     = (COUNT_W + 3)'({nm1, 2'b00}) + (COUNT_W + 3)'(nm1);
	assign runs_fail = (t10 < (TRANS_W + 4)'(nm1)) || ((COUNT_W + 3)'(head.trans) > nm1_5);
	assign num10     = CMP_W'({anum_q, 3'b000}) + CMP_W'({anum_q, 1'b0});
	assign den3      = CMP_W'({aden_q, 1'b0}) + CMP_W'(aden_q);
	assign serial_fail = (aden_q != '0) && (num10 > den3);

	always_comb begin
		if (head.ovf) begin
			verdict = STAT_LONG;
		end else if (head.n < minimum) begin
			verdict = STAT_SKIP;
		end else if (freq_fail) begin
			verdict = STAT_FREQ;
		end else if (runs_fail) begin
			verdict = STAT_RUNS;
		end else if (serial_fail) begin
			verdict = STAT_SERIAL;
		end else begin
			verdict = STAT_PASS;
		end
	end

	assign slot_free = !out_valid_q || verdicts.ready;
	assign pop       = (state_q == B_JUDGE) && slot_free;

	always_ff @(posedge clk) begin
		case (state_q)
			B_PA:    pa_q <= prod[PA_W-1:0];
			B_SS:    ss_q <= prod[SS_W-1:0];
			B_NQ:    nq_q <= prod[PA_W-1:0];
			B_LF:    lf_q <= prod[LF_W-1:0];
			B_DIFF: begin
				num_q <= $signed(NUM_W'(pa_q)) - $signed(NUM_W'(ss_q)) + $signed(NUM_W'(lf_q));
				den_q <= $signed(NUM_W'(nq_q)) - $signed(NUM_W'(ss_q));
			end
			B_ABS: begin
				anum_q <= num_q[NUM_W-1] ? ABS_W'(-num_q) : ABS_W'(num_q);
				aden_q <= den_q[NUM_W-1] ? ABS_W'(-den_q) : ABS_W'(den_q);
			end
			default: begin
			end
		endcase
		if (pop) begin
			passed_q <= (verdict == STAT_PASS) || (verdict == STAT_SKIP);
			status_q <= verdict;
			ones_q   <= head.ones;
			trans_q  <= head.trans;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			min_bytes_q <= MIN_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				min_bytes_q <= cfg.min_bytes;
			end
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (verdicts.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE:  if (head_valid) state_q <= B_PA;
				B_PA:    state_q <= B_SS;
				B_SS:    state_q <= B_NQ;
				B_NQ:    state_q <= B_LF;
				B_LF:    state_q <= B_DIFF;
				B_DIFF:  state_q <= B_ABS;
				B_ABS:   state_q <= B_JUDGE;
				B_JUDGE: if (slot_free) state_q <= B_IDLE;
				default: state_q <= B_IDLE;
			endcase
		end
	end

	assign verdicts.valid            = out_valid_q;
	assign verdicts.passed           = passed_q;
	assign verdicts.status           = status_q;
	assign verdicts.ones_count       = ones_q;
	assign verdicts.transition_count = trans_q;

endmodule

`default_nettype wire
